// ===== design/assert_macros.svh =====
// Assertion macros shared by the command sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NFCS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NFCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/nfcs_pkg.sv =====
// Types, constants and codes shared by the NOR flash command sequencer.
`timescale 1ns / 1ps

package nfcs_pkg;

  localparam int SECTOR_WORDS = 2048;
  localparam int BLOCK_WORDS  = 32768;
  localparam int ADDR_BITS    = 22;

  localparam int AW = 22;  // bus word address width
  localparam int DW = 16;  // bus data width
  localparam int LW = 27;  // poll limit width

  localparam logic [AW-1:0] ADDR_MASK        = AW'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AW-1:0] SECTOR_BASE_MASK = ~AW'(SECTOR_WORDS - 1);
  localparam logic [AW-1:0] BLOCK_BASE_MASK  = ~AW'(BLOCK_WORDS - 1);

  localparam logic [AW-1:0] UNLOCK_ADDR1 = 22'h000555;
  localparam logic [AW-1:0] UNLOCK_ADDR2 = 22'h0002AA;
  localparam logic [AW-1:0] DEV_ID_ADDR  = 22'h000001;

  localparam logic [DW-1:0] D_UNLOCK1      = 16'h00AA;
  localparam logic [DW-1:0] D_UNLOCK2      = 16'h0055;
  localparam logic [DW-1:0] D_ERASE_SETUP  = 16'h0080;
  localparam logic [DW-1:0] D_SECTOR_ERASE = 16'h0050;
  localparam logic [DW-1:0] D_BLOCK_ERASE  = 16'h0030;
  localparam logic [DW-1:0] D_CHIP_ERASE   = 16'h0010;
  localparam logic [DW-1:0] D_PROGRAM      = 16'h00A0;
  localparam logic [DW-1:0] D_ID_ENTRY     = 16'h0090;
  localparam logic [DW-1:0] D_ID_EXIT      = 16'h00F0;
  localparam logic [DW-1:0] MFR_ID         = 16'h00BF;
  localparam logic [DW-1:0] DEV_ID         = 16'h236D;
  localparam logic [DW-1:0] ERASED_WORD    = 16'hFFFF;

  localparam logic [LW-1:0] POLL_LIMIT_RESET = 27'h7FFFFFF;

  typedef enum logic [2:0] {
    FN_READ         = 3'd0,
    FN_PROGRAM      = 3'd1,
    FN_ERASE_SECTOR = 3'd2,
    FN_ERASE_BLOCK  = 3'd3,
    FN_ERASE_CHIP   = 3'd4,
    FN_IDENTIFY     = 3'd5,
    FN_RESET        = 3'd6,
    FN_DATA         = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    K_WRITE = 2'd0,
    K_READ  = 2'd1,
    K_DONE  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_READ        = 4'd1,
    PH_PROG        = 4'd2,
    PH_POLL_SECTOR = 4'd3,
    PH_POLL_BLOCK  = 4'd4,
    PH_POLL_CHIP   = 4'd5,
    PH_VER_SECTOR  = 4'd6,
    PH_VER_BLOCK   = 4'd7,
    PH_ID_FIRST    = 4'd8,
    PH_ID_SECOND   = 4'd9
  } phase_t;

  // Fixed write prefix of a result burst
  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_CMD   = 2'd1,  // unlock pair + command word at 0x555
    PFX_ERASE = 2'd2   // unlock pair, erase setup, unlock pair
  } pfx_t;

  typedef struct packed {
    func_t         func;
    logic [AW-1:0] address;
    logic [DW-1:0] value;
  } in_item_t;

  typedef struct packed {
    kind_t         kind;
    logic [AW-1:0] bus_address;
    logic [DW-1:0] bus_data;
    logic          success;
    logic          last;
  } out_item_t;

  // Compact description of all results caused by one item
  typedef struct packed {
    pfx_t          pfx;
    logic [DW-1:0] cmd;
    logic          mid_en;
    logic [AW-1:0] mid_addr;
    logic [DW-1:0] mid_data;
    kind_t         fin_kind;
    logic [AW-1:0] fin_addr;
    logic [DW-1:0] fin_data;
    logic          fin_ok;
  } script_t;

endpackage

// ===== design/nfcs_emit.sv =====
// Result emitter: holds one burst description and sends its items one per cycle while out_ready is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfcs_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  nfcs_pkg::script_t   script_in,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output nfcs_pkg::out_item_t out_data
);
  import nfcs_pkg::*;

  script_t    script_r;
  logic       vld_r;
  logic [2:0] step_r;
  logic [2:0] pfx_n;
  logic [2:0] last_idx;
  logic       is_last;
  out_item_t  o;

  always_comb begin
    unique case (script_r.pfx)
      PFX_CMD:   pfx_n = 3'd3;
      PFX_ERASE: pfx_n = 3'd5;
      default:   pfx_n = 3'd0;
    endcase
    last_idx = pfx_n + {2'b00, script_r.mid_en};
    is_last  = (step_r == last_idx);
  end

  always_comb begin
    o = '0;
    if (step_r < pfx_n) begin
      o.kind = K_WRITE;
      unique case (step_r)
        3'd1, 3'd4: begin
          o.bus_address = UNLOCK_ADDR2;
          o.bus_data    = D_UNLOCK2;
        end
        3'd2: begin
          o.bus_address = UNLOCK_ADDR1;
          o.bus_data    = (script_r.pfx == PFX_ERASE) ? D_ERASE_SETUP : script_r.cmd;
        end
        default: begin
          o.bus_address = UNLOCK_ADDR1;
          o.bus_data    = D_UNLOCK1;
        end
      endcase
    end else if (script_r.mid_en && step_r == pfx_n) begin
      o.kind        = K_WRITE;
      o.bus_address = script_r.mid_addr;
      o.bus_data    = script_r.mid_data;
    end else begin
      o.kind        = script_r.fin_kind;
      o.bus_address = script_r.fin_addr;
      o.bus_data    = script_r.fin_data;
      o.success     = script_r.fin_ok;
    end
    o.bus_address = o.bus_address & ADDR_MASK;
    o.last        = is_last;
  end

  assign out_data  = o;
  assign out_valid = vld_r;
  assign load_ok   = !vld_r || (out_ready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      step_r <= 3'd0;
    end else if (load) begin
      vld_r  <= 1'b1;
      step_r <= 3'd0;
    end else if (vld_r && out_ready) begin
      if (is_last) begin
        vld_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      script_r <= script_in;
    end
  end

  `NFCS_ASSERT(a_done_is_last, out_valid && out_data.kind == K_DONE, out_data.last,
    "done item not marked last")
  `NFCS_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !out_data.last, out_valid,
    "burst dropped before its last item")
  `NFCS_ASSERT(a_step_in_range, vld_r, step_r <= last_idx, "emitter step past burst end")

endmodule

// ===== design/nfcs_decode.sv =====
// Command decoder: sequencer state, poll limit register and burst selection per item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfcs_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nfcs_pkg::LW-1:0]     cfg_wdata,
  input  logic                        item_vld,
  input  nfcs_pkg::in_item_t          item,
  input  logic                        take,
  output logic                        script_vld,
  output nfcs_pkg::script_t           script
);
  import nfcs_pkg::*;

  localparam logic [16:0] SECTOR_W17 = 17'(SECTOR_WORDS);
  localparam logic [16:0] BLOCK_W17  = 17'(BLOCK_WORDS);

  phase_t        phase_r, phase_nxt;
  logic [AW-1:0] ta_r, ta_nxt;
  logic [DW-1:0] tw_r, tw_nxt;
  logic [LW-1:0] pc_r, pc_nxt;
  logic [15:0]   vi_r, vi_nxt;
  logic [DW-1:0] first_id_r, first_id_nxt;
  logic [LW-1:0] poll_limit_r;

  logic [LW-1:0] lim;
  logic [LW:0]   pc_inc;
  logic [16:0]   vi_inc;
  logic [16:0]   words;

  assign lim    = (poll_limit_r == '0) ? LW'(1) : poll_limit_r;
  assign pc_inc = {1'b0, pc_r} + {{LW{1'b0}}, 1'b1};
  assign vi_inc = {1'b0, vi_r} + 17'd1;
  assign words  = (phase_r == PH_VER_SECTOR) ? SECTOR_W17 : BLOCK_W17;

  always_comb begin
    phase_nxt    = phase_r;
    ta_nxt       = ta_r;
    tw_nxt       = tw_r;
    pc_nxt       = pc_r;
    vi_nxt       = vi_r;
    first_id_nxt = first_id_r;
    script       = '0;
    script_vld   = 1'b0;

    priority if (item.func == FN_RESET) begin
      script_vld      = item_vld;
      script.pfx      = PFX_CMD;
      script.cmd      = D_ID_EXIT;
      script.fin_kind = K_DONE;
      script.fin_ok   = 1'b1;
      phase_nxt       = PH_IDLE;
    end else if (item.func == FN_DATA) begin
      script.fin_addr = ta_r;
      unique case (phase_r)
        PH_READ: begin
          script_vld      = item_vld;
          script.fin_kind = K_DONE;
          script.fin_data = item.value;
          script.fin_ok   = 1'b1;
          phase_nxt       = PH_IDLE;
        end
        PH_PROG: begin
          script_vld = item_vld;
          if (item.value == tw_r) begin
            script.fin_kind = K_DONE;
            script.fin_ok   = 1'b1;
            phase_nxt       = PH_IDLE;
          end else if (pc_r >= lim) begin
            script.fin_kind = K_DONE;
            phase_nxt       = PH_IDLE;
          end else begin
            script.fin_kind = K_READ;
            pc_nxt          = pc_inc[LW-1:0];
          end
        end
        PH_POLL_SECTOR, PH_POLL_BLOCK, PH_POLL_CHIP: begin
          script_vld = item_vld;
          if (item.value[7]) begin
            if (phase_r == PH_POLL_CHIP) begin
              script.fin_kind = K_DONE;
              script.fin_ok   = 1'b1;
              phase_nxt       = PH_IDLE;
            end else begin
              script.fin_kind = K_READ;
              vi_nxt          = '0;
              phase_nxt       = (phase_r == PH_POLL_SECTOR) ? PH_VER_SECTOR : PH_VER_BLOCK;
            end
          end else if (pc_inc >= {1'b0, lim}) begin
            script.fin_kind = K_DONE;
            phase_nxt       = PH_IDLE;
          end else begin
            script.fin_kind = K_READ;
            pc_nxt          = pc_inc[LW-1:0];
          end
        end
        PH_VER_SECTOR, PH_VER_BLOCK: begin
          script_vld = item_vld;
          if (item.value != ERASED_WORD) begin
            script.fin_kind = K_DONE;
            phase_nxt       = PH_IDLE;
          end else if (vi_inc >= words) begin
            script.fin_kind = K_DONE;
            script.fin_ok   = 1'b1;
            phase_nxt       = PH_IDLE;
          end else begin
            script.fin_kind = K_READ;
            script.fin_addr = ta_r + AW'(vi_inc[15:0]);
            vi_nxt          = vi_inc[15:0];
          end
        end
        PH_ID_FIRST: begin
          script_vld      = item_vld;
          script.fin_kind = K_READ;
          script.fin_addr = DEV_ID_ADDR;
          first_id_nxt    = item.value;
          phase_nxt       = PH_ID_SECOND;
        end
        PH_ID_SECOND: begin
          script_vld      = item_vld;
          script.pfx      = PFX_CMD;
          script.cmd      = D_ID_EXIT;
          script.fin_kind = K_DONE;
          script.fin_addr = '0;
          script.fin_ok   = (first_id_r == MFR_ID) && (item.value == DEV_ID);
          phase_nxt       = PH_IDLE;
        end
        default: ;  // idle: stray read data is dropped
      endcase
    end else if (phase_r == PH_IDLE) begin
      script_vld      = item_vld;
      pc_nxt          = '0;
      vi_nxt          = '0;
      script.fin_kind = K_READ;
      unique case (item.func)
        FN_READ: begin
          ta_nxt          = item.address;
          script.fin_addr = item.address;
          phase_nxt       = PH_READ;
        end
        FN_PROGRAM: begin
          ta_nxt          = item.address;
          tw_nxt          = item.value;
          script.pfx      = PFX_CMD;
          script.cmd      = D_PROGRAM;
          script.mid_en   = 1'b1;
          script.mid_addr = item.address;
          script.mid_data = item.value;
          script.fin_addr = item.address;
          phase_nxt       = PH_PROG;
        end
        FN_ERASE_SECTOR: begin
          ta_nxt          = item.address & SECTOR_BASE_MASK;
          script.pfx      = PFX_ERASE;
          script.mid_en   = 1'b1;
          script.mid_addr = item.address & SECTOR_BASE_MASK;
          script.mid_data = D_SECTOR_ERASE;
          script.fin_addr = item.address & SECTOR_BASE_MASK;
          phase_nxt       = PH_POLL_SECTOR;
        end
        FN_ERASE_BLOCK: begin
          ta_nxt          = item.address & BLOCK_BASE_MASK;
          script.pfx      = PFX_ERASE;
          script.mid_en   = 1'b1;
          script.mid_addr = item.address & BLOCK_BASE_MASK;
          script.mid_data = D_BLOCK_ERASE;
          script.fin_addr = item.address & BLOCK_BASE_MASK;
          phase_nxt       = PH_POLL_BLOCK;
        end
        FN_ERASE_CHIP: begin
          ta_nxt          = '0;
          script.pfx      = PFX_ERASE;
          script.mid_en   = 1'b1;
          script.mid_addr = UNLOCK_ADDR1;
          script.mid_data = D_CHIP_ERASE;
          phase_nxt       = PH_POLL_CHIP;
        end
        default: begin  // identify
          ta_nxt     = '0;
          script.pfx = PFX_CMD;
          script.cmd = D_ID_ENTRY;
          phase_nxt  = PH_ID_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ta_r         <= '0;
      tw_r         <= '0;
      pc_r         <= '0;
      vi_r         <= '0;
      first_id_r   <= '0;
      poll_limit_r <= POLL_LIMIT_RESET;
    end else begin
      if (take) begin
        phase_r    <= phase_nxt;
        ta_r       <= ta_nxt;
        tw_r       <= tw_nxt;
        pc_r       <= pc_nxt;
        vi_r       <= vi_nxt;
        first_id_r <= first_id_nxt;
      end
      if (cfg_we) begin
        poll_limit_r <= cfg_wdata;
      end
    end
  end

  `NFCS_ASSERT_NEXT(a_reset_cmd_idles, take && item.func == FN_RESET, phase_r == PH_IDLE,
    "reset command did not return to idle")
  `NFCS_ASSERT(a_busy_cmd_silent,
    item_vld && phase_r != PH_IDLE && item.func != FN_DATA && item.func != FN_RESET,
    !script_vld, "command while busy produced results")

endmodule

// ===== design/nor_flash_command_sequencer.sv =====
// Top level of the NOR flash command sequencer: input register, decoder and emitter.
`timescale 1ns / 1ps
//
//  Channel   Ports                              Direction  Carries
//  in        in_valid / in_ready / in_data      in         command or returned read data
//  out       out_valid / out_ready / out_data   out        bus write, read request or done
//  cfg       cfg_we / cfg_wdata                 in         poll limit write
//
//  An item is registered on accept and decoded from the input register; its results
//  leave the emitter one per cycle while out_ready is high: 1 to 7 results per item
//  (program 5, sector/block/chip erase 7, identify 4, reset 4); some items cause none.
//  The next item is decoded while the last result of the previous one is taken.
//  Reset (rst_n low, synchronous) clears the control state and sets the poll limit to its maximum.
//  A stall on out holds the current result; in_ready drops while the input register is full and cannot advance.

module nor_flash_command_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  nfcs_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output nfcs_pkg::out_item_t       out_data,
  input  logic                      cfg_we,
  input  logic [nfcs_pkg::LW-1:0]   cfg_wdata
);
  import nfcs_pkg::*;

  in_item_t in_item_r;
  logic     in_vld_r;
  logic     advance;
  logic     script_vld;
  script_t  script;
  logic     load_ok;

  assign advance  = in_vld_r && (!script_vld || load_ok);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  nfcs_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_vld   (in_vld_r),
    .item       (in_item_r),
    .take       (advance),
    .script_vld (script_vld),
    .script     (script)
  );

  nfcs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && script_vld),
    .script_in (script),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/nor_flash_command_sequencer_tb.sv =====
// Self-checking testbench for the NOR flash command sequencer: directed table, then predicted random traffic.
`timescale 1ns / 1ps

module nor_flash_command_sequencer_tb;
  import nfcs_pkg::*;

  localparam int ROW_MODEL     = 0;  // expectation comes from the predictor
  localparam int ROW_NONE      = 1;  // item must cause no result
  localparam int ROW_ONE       = 2;  // exactly one typed result
  localparam int PHASE_ITEMS   = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct {
    in_item_t  item;
    int        mode;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [LW-1:0] cfg_wdata = '0;

  // sequencer shadow state
  phase_t        sq_phase = PH_IDLE;
  logic [AW-1:0] sq_addr = '0;
  logic [DW-1:0] sq_word = '0;
  int unsigned   sq_polls = 0;
  logic [15:0]   sq_vidx = '0;
  logic [DW-1:0] sq_first_id = '0;
  logic [LW-1:0] sq_limit = POLL_LIMIT_RESET;

  out_item_t pending_bus_cycles[$];
  out_item_t step_results[$];
  int        row_mode = ROW_MODEL;
  out_item_t row_want = '0;
  int        mismatches = 0;
  int unsigned cycle_count = 0;
  bit        gaps_on = 1'b1;
  bit        hold_req = 1'b0;
  int        verify_fail_at = -1;

  nor_flash_command_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("MISMATCH @%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic out_item_t res(kind_t k, logic [AW-1:0] a, logic [DW-1:0] d, logic ok);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.bus_address = a;
    r.bus_data = d;
    r.success = ok;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic row_t mk(func_t f, logic [AW-1:0] a, logic [DW-1:0] v, int mode,
                              out_item_t want);
    row_t r;
    r.item.func = f;
    r.item.address = a;
    r.item.value = v;
    r.mode = mode;
    r.want = want;
    return r;
  endfunction

  task automatic emit(input kind_t k, input logic [AW-1:0] a, input logic [DW-1:0] d,
                      input logic ok);
    out_item_t r;
    r = res(k, a & ADDR_MASK, d, ok);
    r.last = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic emit_unlock();
    emit(K_WRITE, UNLOCK_ADDR1, D_UNLOCK1, 1'b0);
    emit(K_WRITE, UNLOCK_ADDR2, D_UNLOCK2, 1'b0);
  endtask

  task automatic emit_erase_prefix();
    emit_unlock();
    emit(K_WRITE, UNLOCK_ADDR1, D_ERASE_SETUP, 1'b0);
    emit_unlock();
  endtask

  task automatic emit_done(input logic [AW-1:0] a, input logic [DW-1:0] d, input logic ok);
    sq_phase = PH_IDLE;
    emit(K_DONE, a, d, ok);
  endtask

  // Bus cycles and done caused by one accepted item; advances the shadow state.
  task automatic step_sequencer(input in_item_t it);
    int unsigned   lim;
    int unsigned   words;
    logic [AW-1:0] low_bits;
    step_results.delete();
    lim = (sq_limit == '0) ? 1 : sq_limit;
    if (it.func == FN_RESET) begin
      emit_unlock();
      emit(K_WRITE, UNLOCK_ADDR1, D_ID_EXIT, 1'b0);
      emit_done('0, '0, 1'b1);
    end else if (it.func == FN_DATA) begin
      case (sq_phase)
        PH_READ: emit_done(sq_addr, it.value, 1'b1);
        PH_PROG: begin
          if (it.value == sq_word) emit_done(sq_addr, '0, 1'b1);
          else if (sq_polls >= lim) emit_done(sq_addr, '0, 1'b0);
          else begin
            sq_polls++;
            emit(K_READ, sq_addr, '0, 1'b0);
          end
        end
        PH_POLL_SECTOR, PH_POLL_BLOCK, PH_POLL_CHIP: begin
          if (it.value[7]) begin
            if (sq_phase == PH_POLL_CHIP) emit_done(sq_addr, '0, 1'b1);
            else begin
              sq_phase = (sq_phase == PH_POLL_SECTOR) ? PH_VER_SECTOR : PH_VER_BLOCK;
              sq_vidx = '0;
              emit(K_READ, sq_addr, '0, 1'b0);
            end
          end else if (sq_polls + 1 >= lim) emit_done(sq_addr, '0, 1'b0);
          else begin
            sq_polls++;
            emit(K_READ, sq_addr, '0, 1'b0);
          end
        end
        PH_VER_SECTOR, PH_VER_BLOCK: begin
          words = (sq_phase == PH_VER_SECTOR) ? SECTOR_WORDS : BLOCK_WORDS;
          if (it.value != ERASED_WORD) emit_done(sq_addr, '0, 1'b0);
          else if (int'(sq_vidx) + 1 >= words) emit_done(sq_addr, '0, 1'b1);
          else begin
            sq_vidx++;
            emit(K_READ, sq_addr + AW'(sq_vidx), '0, 1'b0);
          end
        end
        PH_ID_FIRST: begin
          sq_first_id = it.value;
          sq_phase = PH_ID_SECOND;
          emit(K_READ, DEV_ID_ADDR, '0, 1'b0);
        end
        PH_ID_SECOND: begin
          emit_unlock();
          emit(K_WRITE, UNLOCK_ADDR1, D_ID_EXIT, 1'b0);
          emit_done('0, '0, sq_first_id == MFR_ID && it.value == DEV_ID);
        end
        default: ;  // stray data while idle
      endcase
    end else if (sq_phase == PH_IDLE) begin
      sq_polls = 0;
      sq_vidx = '0;
      case (it.func)
        FN_READ: begin
          sq_addr = it.address & ADDR_MASK;
          sq_phase = PH_READ;
          emit(K_READ, sq_addr, '0, 1'b0);
        end
        FN_PROGRAM: begin
          sq_addr = it.address & ADDR_MASK;
          sq_word = it.value;
          emit_unlock();
          emit(K_WRITE, UNLOCK_ADDR1, D_PROGRAM, 1'b0);
          emit(K_WRITE, sq_addr, it.value, 1'b0);
          emit(K_READ, sq_addr, '0, 1'b0);
          sq_phase = PH_PROG;
        end
        FN_ERASE_SECTOR, FN_ERASE_BLOCK: begin
          low_bits = (it.func == FN_ERASE_SECTOR) ? AW'(SECTOR_WORDS - 1) : AW'(BLOCK_WORDS - 1);
          sq_addr = it.address & ~low_bits & ADDR_MASK;
          emit_erase_prefix();
          emit(K_WRITE, sq_addr,
               (it.func == FN_ERASE_SECTOR) ? D_SECTOR_ERASE : D_BLOCK_ERASE, 1'b0);
          emit(K_READ, sq_addr, '0, 1'b0);
          sq_phase = (it.func == FN_ERASE_SECTOR) ? PH_POLL_SECTOR : PH_POLL_BLOCK;
        end
        FN_ERASE_CHIP: begin
          sq_addr = '0;
          emit_erase_prefix();
          emit(K_WRITE, UNLOCK_ADDR1, D_CHIP_ERASE, 1'b0);
          emit(K_READ, '0, '0, 1'b0);
          sq_phase = PH_POLL_CHIP;
        end
        default: begin
          sq_addr = '0;
          emit_unlock();
          emit(K_WRITE, UNLOCK_ADDR1, D_ID_ENTRY, 1'b0);
          emit(K_READ, '0, '0, 1'b0);
          sq_phase = PH_ID_FIRST;
        end
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endtask

  // Check results first: nothing can leave in the cycle its item is taken.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_bus_cycles.size() == 0) begin
          flag_mismatch("unexpected result, bus_address", out_data.bus_address, '0);
        end else begin
          w = pending_bus_cycles.pop_front();
          if (out_data.kind != w.kind) flag_mismatch("kind", out_data.kind, w.kind);
          if (out_data.bus_address != w.bus_address)
            flag_mismatch("bus_address", out_data.bus_address, w.bus_address);
          if (out_data.bus_data != w.bus_data)
            flag_mismatch("bus_data", out_data.bus_data, w.bus_data);
          if (out_data.success != w.success)
            flag_mismatch("success", out_data.success, w.success);
          if (out_data.last != w.last) flag_mismatch("last", out_data.last, w.last);
        end
      end
      if (in_valid && in_ready) begin
        step_sequencer(in_data);
        if (row_mode == ROW_ONE) pending_bus_cycles.push_back(row_want);
        else if (row_mode == ROW_MODEL)
          foreach (step_results[i]) pending_bus_cycles.push_back(step_results[i]);
      end
    end
  end

  initial begin : receiver
    int stall;
    int held;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 13) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send(input in_item_t it, input int mode, input out_item_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data = it;
    row_mode = mode;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    int spins;
    spins = 0;
    while (pending_bus_cycles.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_poll_limit(input logic [LW-1:0] v);
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(posedge clk);
    sq_limit = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly new commands while idle and answers that fit the command in progress; some resets and ignored items.
  task automatic pick_item(output in_item_t it, output bit counts);
    int r;
    it.func = FN_DATA;
    it.address = AW'($urandom);
    it.value = DW'($urandom);
    r = $urandom_range(0, 7);
    if (r == 0) it.address = '1;
    else if (r == 1) it.address = '0;
    counts = 1'b1;
    case (sq_phase)
      PH_IDLE: begin
        r = $urandom_range(0, 15);
        if (r == 0) counts = 1'b0;
        else if (r == 1) it.func = FN_RESET;
        else it.func = func_t'($urandom_range(0, 5));
      end
      PH_VER_SECTOR, PH_VER_BLOCK: begin
        counts = 1'b0;
        if (verify_fail_at >= 0 && int'(sq_vidx) >= verify_fail_at) begin
          if (it.value == ERASED_WORD) it.value = ~ERASED_WORD;
        end else begin
          it.value = ERASED_WORD;
        end
      end
      default: begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          it.func = FN_RESET;
        end else if (r == 1) begin
          it.func = func_t'($urandom_range(0, 5));
          counts = 1'b0;
        end else begin
          case (sq_phase)
            PH_PROG: if ($urandom_range(0, 2) == 0) it.value = sq_word;
            PH_POLL_SECTOR, PH_POLL_BLOCK, PH_POLL_CHIP: begin
              it.value[7] = ($urandom_range(0, 2) == 0);
              // erase verify ends on a bad word within its first eight reads
              if (it.value[7]) verify_fail_at = $urandom_range(0, 7);
            end
            PH_ID_FIRST: if ($urandom_range(0, 1) == 0) it.value = MFR_ID;
            PH_ID_SECOND: if ($urandom_range(0, 1) == 0) it.value = DEV_ID;
            default: ;
          endcase
        end
      end
    endcase
  endtask

  initial begin : stimulus
    row_t          rows[$];
    in_item_t      it;
    bit            counts;
    int            taken;
    int            ph;
    logic [LW-1:0] limits[5];
    out_item_t     w;

    rows.push_back(mk(FN_DATA, '1, '1, ROW_NONE, '0));
    rows.push_back(mk(FN_READ, '1, '0, ROW_ONE, res(K_READ, '1, '0, 1'b0)));
    rows.push_back(mk(FN_DATA, '0, '1, ROW_ONE, res(K_DONE, '1, '1, 1'b1)));
    rows.push_back(mk(FN_READ, '0, '1, ROW_ONE, res(K_READ, '0, '0, 1'b0)));
    rows.push_back(mk(FN_DATA, '1, '0, ROW_ONE, res(K_DONE, '0, '0, 1'b1)));
    rows.push_back(mk(FN_PROGRAM, '1, '1, ROW_MODEL, '0));
    rows.push_back(mk(FN_READ, 22'h000123, '0, ROW_NONE, '0));  // busy: ignored
    rows.push_back(mk(FN_DATA, '0, 16'h1234, ROW_ONE, res(K_READ, '1, '0, 1'b0)));
    rows.push_back(mk(FN_DATA, '0, '1, ROW_ONE, res(K_DONE, '1, '0, 1'b1)));
    rows.push_back(mk(FN_ERASE_SECTOR, 22'h2ABCDE, '0, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h0000, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h0080, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h0000, ROW_ONE, res(K_DONE, 22'h2AB800, '0, 1'b0)));
    rows.push_back(mk(FN_ERASE_BLOCK, '1, '1, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h0080, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, '1, ROW_MODEL, '0));
    rows.push_back(mk(FN_RESET, '1, '1, ROW_MODEL, '0));  // abort in the middle of verify
    rows.push_back(mk(FN_ERASE_CHIP, '1, '0, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h0080, ROW_ONE, res(K_DONE, '0, '0, 1'b1)));
    rows.push_back(mk(FN_IDENTIFY, '0, '0, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, MFR_ID, ROW_ONE, res(K_READ, DEV_ID_ADDR, '0, 1'b0)));
    rows.push_back(mk(FN_DATA, '0, DEV_ID, ROW_MODEL, '0));
    rows.push_back(mk(FN_IDENTIFY, '1, '1, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, 16'h00BE, ROW_MODEL, '0));
    rows.push_back(mk(FN_DATA, '0, DEV_ID, ROW_MODEL, '0));  // ID mismatch
    rows.push_back(mk(FN_RESET, '0, '0, ROW_MODEL, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send(rows[i].item, rows[i].mode, rows[i].want);
    in_valid = 1'b0;
    settle();

    limits[0] = 27'd1;
    limits[1] = 27'd0;
    limits[2] = 27'd3;
    limits[3] = POLL_LIMIT_RESET;
    limits[4] = LW'($urandom_range(2, 12));
    for (ph = 0; ph < 5; ph++) begin
      write_poll_limit(limits[ph]);
      gaps_on = (ph != 4);
      if (ph == 2) hold_req = 1'b1;  // long output stall while items keep coming
      taken = 0;
      while (taken < PHASE_ITEMS || sq_phase != PH_IDLE) begin
        pick_item(it, counts);
        send(it, ROW_MODEL, '0);
        if (counts) taken++;
        if (ph == 0 && counts && taken == PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          settle();
        end
      end
      in_valid = 1'b0;
      settle();
    end

    while (pending_bus_cycles.size() != 0) begin
      w = pending_bus_cycles.pop_front();
      flag_mismatch("missing result, bus_address", '0, w.bus_address);
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/nfcs_pkg.sv
design/nfcs_emit.sv
design/nfcs_decode.sv
design/nor_flash_command_sequencer.sv
tb/sv/nor_flash_command_sequencer_tb.sv
